/* rtl/jafp_pkg.sv */
// ----------------------------------------------------------------------------
// jafp_pkg
// Shared constants, types and the field locator for the joystick frame parser.
// ----------------------------------------------------------------------------
package jafp_pkg;

   localparam int FRAME_BYTES = 23;
   localparam int FIELD_CHARS = 4;
   localparam int FIELD_COUNT = 4;
   localparam int POS_W       = $clog2(FRAME_BYTES + 2);
   localparam int SLOT_W      = $clog2(FIELD_COUNT);
   localparam int MAG_W       = 14;
   localparam int VALUE_W     = 15;

   localparam logic [7:0] START_RESET = 8'd115;
   localparam logic [7:0] CHAR_ZERO   = 8'd48;
   localparam logic [7:0] CHAR_NINE   = 8'd57;
   localparam logic [7:0] CHAR_PLUS   = 8'd43;
   localparam logic [7:0] CHAR_MINUS  = 8'd45;
   localparam logic [7:0] CHAR_SPACE  = 8'd32;
   localparam logic [7:0] CHAR_TAB    = 8'd9;
   localparam logic [7:0] CHAR_CR     = 8'd13;

   localparam logic [POS_W-1:0] POS_SAT = POS_W'(FRAME_BYTES + 1);
   localparam logic [POS_W-1:0] POS_END = POS_W'(FRAME_BYTES);

   typedef logic [POS_W-1:0] pos_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef value_type values_type [FIELD_COUNT];

   typedef logic [POS_W-1:0] offsets_type [FIELD_COUNT];
   localparam offsets_type FIELD_OFFSET = '{POS_W'(2), POS_W'(7), POS_W'(12), POS_W'(17)};

   typedef struct packed {
      logic              step;       // a byte of the frame is being consumed
      logic              hit;        // byte lies inside a numeric field
      logic              first;      // first character of that field
      logic              last_char;  // last character of that field
      logic [SLOT_W-1:0] slot;
      logic              clear;      // frame ends with this byte
   } fld_ctrl_type;

   function automatic fld_ctrl_type locate_field(input pos_type pos);
      fld_ctrl_type r;
      r = '0;
      if (pos < POS_END) begin
         for (int k = 0; k < FIELD_COUNT; k++) begin
            if (pos >= FIELD_OFFSET[k] &&
                pos < FIELD_OFFSET[k] + POS_W'(FIELD_CHARS)) begin
               r.hit       = 1'b1;
               r.slot      = SLOT_W'(k);
               r.first     = (pos == FIELD_OFFSET[k]);
               r.last_char = (pos == FIELD_OFFSET[k] + POS_W'(FIELD_CHARS - 1));
            end
         end
      end
      return r;
   endfunction

endpackage

/* rtl/joystick_ascii_frame_parser.sv */
// ----------------------------------------------------------------------------
// joystick_ascii_frame_parser
// Checks received serial frames and converts the four stick fields.
// ----------------------------------------------------------------------------
//  channel | direction | handshake      | transaction
//  req_    | in        | valid / stall  | one received byte, last-byte flag
//  rsp_    | out       | valid / stall  | accept flag and four stick values
//  csr_    | in        | valid / ready  | start character write
//
// One byte per cycle sustained while the input is not stalled; an accepted byte
// sits in the input register and is processed from there, and a frame's result
// is registered into the output register when its last byte is processed.
// Synchronous reset clears all frame state; start character returns to 's'.
// A stalled result only holds up the last byte of the next frame; other bytes
// keep flowing.
module joystick_ascii_frame_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_rx_byte,
   input  logic                req_frame_end,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_frame_ok,
   output jafp_pkg::value_type rsp_left_x,
   output jafp_pkg::value_type rsp_left_y,
   output jafp_pkg::value_type rsp_right_x,
   output jafp_pkg::value_type rsp_right_y,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [7:0]          csr_start_char
);
   import jafp_pkg::*;

   logic [7:0]   start_ff;
   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         in_end_ff;
   pos_type      pos_ff, pos_in;
   logic         bad_ff, bad_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         ok_ff;
   values_type   out_ff;
   values_type   values;

   logic         advance;
   logic         take;
   logic         emit;
   logic         ok;
   fld_ctrl_type ctrl;

   assign csr_ready = 1'b1;

   assign advance   = in_valid_ff && (!in_end_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign emit      = advance && in_end_ff;

   always_comb begin
      ctrl       = locate_field(pos_ff);
      ctrl.step  = advance;
      ctrl.clear = in_end_ff;
   end

   jafp_field_unit u_field (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .rx_byte (in_byte_ff),
      .values  (values)
   );

   always_comb begin
      in_valid_in = take || (in_valid_ff && !advance);
      bad_in      = bad_ff;
      pos_in      = pos_ff;
      if (advance) begin
         if (in_byte_ff == 8'd0 || (pos_ff == '0 && in_byte_ff != start_ff)) begin
            bad_in = 1'b1;
         end
         if (pos_ff != POS_SAT) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
      ok = !bad_in && (pos_in == POS_END);
      if (emit) begin
         bad_in = 1'b0;
         pos_in = '0;
      end
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= START_RESET;
         in_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            start_ff <= csr_start_char;
         end
         in_valid_ff  <= in_valid_in;
         pos_ff       <= pos_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_rx_byte;
         in_end_ff  <= req_frame_end;
      end
      if (emit) begin
         ok_ff <= ok;
         for (int k = 0; k < FIELD_COUNT; k++) begin
            out_ff[k] <= ok ? values[k] : '0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_frame_ok = ok_ff;
   assign rsp_left_x   = out_ff[0];
   assign rsp_left_y   = out_ff[1];
   assign rsp_right_x  = out_ff[2];
   assign rsp_right_y  = out_ff[3];

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !ok_ff) |-> (out_ff[0] == '0 && out_ff[1] == '0 &&
                                    out_ff[2] == '0 && out_ff[3] == '0))
      else $error("rejected frame carries non-zero values");

   a_pos_clear: assert property (@(posedge clock) disable iff (reset)
      emit |=> (pos_ff == '0 && !bad_ff))
      else $error("frame state not cleared after last byte");

   a_stall_only_end: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_end_ff && rsp_valid_ff))
      else $error("input stalled without a pending result");

   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_SAT)
      else $error("byte position beyond saturation");

endmodule

/* rtl/jafp_field_unit.sv */
// ----------------------------------------------------------------------------
// jafp_field_unit
// Per-field integer conversion and storage of the four stick values.
// ----------------------------------------------------------------------------
module jafp_field_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  jafp_pkg::fld_ctrl_type ctrl,
   input  logic [7:0]           rx_byte,
   output jafp_pkg::values_type values
);
   import jafp_pkg::*;

   localparam logic [1:0] PH_SKIP = 2'd0;
   localparam logic [1:0] PH_NUM  = 2'd1;
   localparam logic [1:0] PH_STOP = 2'd2;

   logic [1:0]       phase_ff, phase_in;
   logic             neg_ff, neg_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   values_type       values_ff, values_in;
   values_type       values_pre;

   logic [1:0]       ph_cur;
   logic             neg_cur;
   logic [MAG_W-1:0] mag_cur;
   logic             is_digit;
   logic             is_blank;
   logic [MAG_W-1:0] digit;
   logic [MAG_W:0]   mag_ext;

   always_comb begin
      is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
      is_blank = (rx_byte == CHAR_SPACE) || ((rx_byte >= CHAR_TAB) && (rx_byte <= CHAR_CR));
      digit    = MAG_W'(rx_byte[3:0]);

      ph_cur  = ctrl.first ? PH_SKIP : phase_ff;
      neg_cur = ctrl.first ? 1'b0    : neg_ff;
      mag_cur = ctrl.first ? '0      : mag_ff;

      phase_in  = phase_ff;
      neg_in    = neg_ff;
      mag_in    = mag_ff;
      values_in = values_ff;
      mag_ext   = '0;

      if (ctrl.step && ctrl.hit) begin
         phase_in = ph_cur;
         neg_in   = neg_cur;
         mag_in   = mag_cur;
         unique case (ph_cur)
            PH_SKIP: begin
               if (is_blank) begin
                  phase_in = PH_SKIP;
               end else if (rx_byte == CHAR_PLUS) begin
                  phase_in = PH_NUM;
               end else if (rx_byte == CHAR_MINUS) begin
                  phase_in = PH_NUM;
                  neg_in   = 1'b1;
               end else if (is_digit) begin
                  phase_in = PH_NUM;
                  mag_in   = digit;
               end else begin
                  phase_in = PH_STOP;
               end
            end
            PH_NUM: begin
               if (is_digit) begin
                  mag_in = (mag_cur << 3) + (mag_cur << 1) + digit;
               end else begin
                  phase_in = PH_STOP;
               end
            end
            default: begin
               phase_in = ph_cur;
            end
         endcase
         if (ctrl.last_char) begin
            mag_ext = {1'b0, mag_in};
            values_in[ctrl.slot] = neg_in ? value_type'(-mag_ext) : value_type'(mag_ext);
         end
      end

      values_pre = values_in;

      if (ctrl.step && ctrl.clear) begin
         phase_in = PH_SKIP;
         neg_in   = 1'b0;
         mag_in   = '0;
         for (int k = 0; k < FIELD_COUNT; k++) begin
            values_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         neg_ff   <= 1'b0;
         mag_ff   <= '0;
         for (int k = 0; k < FIELD_COUNT; k++) begin
            values_ff[k] <= '0;
         end
      end else begin
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
         mag_ff    <= mag_in;
         values_ff <= values_in;
      end
   end

   // values of the current frame including this byte, before the end-of-frame clear
   assign values = values_pre;

endmodule
